[design/sbt_pkg.sv]
// sbt_pkg: status codes and cell control bundle for the sorted byte table.
// No dependencies; used by sbt_cell and sorted_byte_table_core.
package sbt_pkg;

    localparam int ValueWidth  = 8;
    localparam int StatusWidth = 3;
    localparam int CountWidth  = 5;

    typedef enum logic [StatusWidth-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Broadcast to every cell in the row for one beat.
    typedef struct packed {
        logic                  ins_en;   // insert accepted, table not full
        logic                  del_en;   // delete accepted and a match exists
        logic [ValueWidth-1:0] value;
    } t_cell_ctrl;

endpackage

[design/sbt_cell.sv]
// sbt_cell: one slot of the sorted table, holds an entry and its valid bit.
// Depends on sbt_pkg for the broadcast control bundle.
module sbt_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sbt_pkg::t_cell_ctrl            i_ctrl,
    input  logic                           i_left_gt,
    input  logic [sbt_pkg::ValueWidth-1:0] i_left_data,
    input  logic                           i_left_valid,
    input  logic [sbt_pkg::ValueWidth-1:0] i_right_data,
    input  logic                           i_right_valid,
    output logic                           o_gt,
    output logic                           o_eq,
    output logic [sbt_pkg::ValueWidth-1:0] o_data,
    output logic                           o_valid
);

    logic [sbt_pkg::ValueWidth-1:0] r_data, n_data;
    logic                           r_valid, n_valid;
    logic                           ge;

    // Value sits above this entry: the insert point lies further right.
    assign o_gt = r_valid && (i_ctrl.value > r_data);
    assign o_eq = r_valid && (i_ctrl.value == r_data);
    assign ge   = r_valid && (r_data >= i_ctrl.value);

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.ins_en && !o_gt) begin
            if (i_left_gt) begin
                n_data  = i_ctrl.value;
                n_valid = 1'b1;
            end else begin
                n_data  = i_left_data;
                n_valid = i_left_valid;
            end
        end else if (i_ctrl.del_en && ge) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

[design/sorted_byte_table_core.sv]
// sorted_byte_table_core: top level, a row of sbt_cell slots kept in ascending order.
// Depends on sbt_pkg and sbt_cell.
//
//  channel   | ports                              | handshake
//  ----------+------------------------------------+--------------------------------
//  command   | i_operation, i_value               | beat taken when start && !busy
//  result    | o_status, o_entry_count            | o_valid high for one cycle
//
// One operation per cycle: every cell compares the broadcast value with its
// own entry and with its left neighbor's verdict, then keeps, loads or shifts
// in the same edge. The only row-wide term is the OR of the match flags that
// gates a delete. The result is registered and appears in the cycle after the command beat.
// Reset (i_rst_n low, synchronous) empties the table and drops any result.
// busy stays low; the receiver cannot stall, so nothing is held back.
module sorted_byte_table_core #(
    parameter int CAPACITY = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_operation,
    input  logic [sbt_pkg::ValueWidth-1:0]  i_value,
    output logic                            o_valid,
    output logic [sbt_pkg::StatusWidth-1:0] o_status,
    output logic [sbt_pkg::CountWidth-1:0]  o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CAPACITY-1:0]            gt_vec, eq_vec, valid_vec;
    logic [sbt_pkg::ValueWidth-1:0] data_vec [CAPACITY];
    sbt_pkg::t_cell_ctrl            ctrl;

    logic                           accept, is_full, is_empty, found;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_valid;
    sbt_pkg::t_status               r_status, n_status;
    logic [CW+sbt_pkg::CountWidth-1:0] count_wide;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    // Last slot valid means no room; first slot empty means nothing stored.
    assign is_full  = valid_vec[CAPACITY-1];
    assign is_empty = !valid_vec[0];
    assign found    = |eq_vec;

    always_comb begin
        ctrl.value  = i_value;
        ctrl.ins_en = accept && (i_operation == sbt_pkg::OP_INSERT) && !is_full;
        ctrl.del_en = accept && (i_operation == sbt_pkg::OP_DELETE) && found;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                           left_gt, left_valid, right_valid;
            logic [sbt_pkg::ValueWidth-1:0] left_data, right_data;

            if (g == 0) begin : g_head
                // Nothing to the left: an insert lands here unless value is larger.
                assign left_gt    = 1'b1;
                assign left_data  = '0;
                assign left_valid = 1'b0;
            end else begin : g_mid
                assign left_gt    = gt_vec[g-1];
                assign left_data  = data_vec[g-1];
                assign left_valid = valid_vec[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                // Shift an empty slot in at the end of a delete.
                assign right_data  = '0;
                assign right_valid = 1'b0;
            end else begin : g_body
                assign right_data  = data_vec[g+1];
                assign right_valid = valid_vec[g+1];
            end

            sbt_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_left_gt    (left_gt),
                .i_left_data  (left_data),
                .i_left_valid (left_valid),
                .i_right_data (right_data),
                .i_right_valid(right_valid),
                .o_gt         (gt_vec[g]),
                .o_eq         (eq_vec[g]),
                .o_data       (data_vec[g]),
                .o_valid      (valid_vec[g])
            );
        end
    endgenerate

    // Status and count bookkeeping for the result beat.
    always_comb begin
        n_count = r_count;
        if (i_operation == sbt_pkg::OP_INSERT) begin
            if (is_full) begin
                n_status = sbt_pkg::ST_FULL;
            end else begin
                n_status = sbt_pkg::ST_INSERTED;
                n_count  = r_count + CW'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = sbt_pkg::ST_EMPTY;
            end else if (!found) begin
                n_status = sbt_pkg::ST_NOT_FOUND;
            end else begin
                n_status = sbt_pkg::ST_DELETED;
                n_count  = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_status <= n_status;
        end
    end

    // Report only the low bits of the count when the table is wider than the field.
    assign count_wide    = {{sbt_pkg::CountWidth{1'b0}}, r_count};
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_entry_count = count_wide[sbt_pkg::CountWidth-1:0];

endmodule
